// ----- rtl/tcw_pkg.sv -----
package tcw_pkg;

    localparam int unsigned ACT_W  = 3;
    localparam int unsigned CHAR_W = 8;
    localparam int unsigned COLA_W = 7;
    localparam int unsigned ROWA_W = 5;
    localparam int unsigned CELL_W = 16;
    localparam int unsigned CCOL_W = 7;
    localparam int unsigned CROW_W = 5;
    localparam int unsigned POS_W  = 11;
    localparam int unsigned COLOR_W = 8;

    localparam logic [ACT_W-1:0] ACT_PRINT     = 3'd0;
    localparam logic [ACT_W-1:0] ACT_SET_CUR   = 3'd1;
    localparam logic [ACT_W-1:0] ACT_CLEAR_ROW = 3'd2;
    localparam logic [ACT_W-1:0] ACT_CLEAR_ALL = 3'd3;
    localparam logic [ACT_W-1:0] ACT_READ      = 3'd4;

    localparam logic [CHAR_W-1:0]  NEWLINE_CODE = 8'h0A;
    localparam logic [CHAR_W-1:0]  BLANK_CODE   = 8'h20;
    localparam logic [COLOR_W-1:0] COLOR_RESET  = 8'h0F;

    typedef enum logic [2:0] {
        CUR_HOLD,
        CUR_SET_ARG,
        CUR_NEXT_LINE,
        CUR_HOME_ROW,
        CUR_HOME,
        CUR_ADVANCE
    } cur_op_t;

    typedef enum logic [2:0] {
        SWP_NONE,
        SWP_ALL,
        SWP_ROW,
        SWP_LAST,
        SWP_COPY,
        SWP_STEP
    } sweep_op_t;

    typedef enum logic [2:0] {
        MEM_NONE,
        MEM_FILL_ZERO,
        MEM_FILL_BLANK,
        MEM_WRITE_CHAR,
        MEM_READ_ARG,
        MEM_COPY
    } mem_op_t;

    typedef struct packed {
        logic      load_item;
        cur_op_t   cur_op;
        sweep_op_t sweep_op;
        mem_op_t   mem_op;
        logic      res_load;
        logic      res_err;
        logic      res_cell;
    } cmd_t;

    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic             char_is_nl;
        logic             col_at_end;
        logic             line_at_last;
        logic             set_ok;
        logic             row_ok;
        logic             read_ok;
        logic             sweep_done;
        logic             out_free;
    } sts_t;

endpackage

// ----- rtl/tcw_ctrl.sv -----
module tcw_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  tcw_pkg::sts_t sts,
    output tcw_pkg::cmd_t cmd
);

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_DISPATCH,
        ST_NEXT_LINE,
        ST_COPY,
        ST_DRAIN,
        ST_BLANK_LAST,
        ST_AFTER_LINE,
        ST_WRITE_CHAR,
        ST_BLANK_SWEEP,
        ST_READ_WAIT,
        ST_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   wrap_reg, wrap_next;
    logic   err_reg, err_next;
    logic   cell_reg, cell_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_INIT;
            wrap_reg  <= 1'b0;
            err_reg   <= 1'b0;
            cell_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            wrap_reg  <= wrap_next;
            err_reg   <= err_next;
            cell_reg  <= cell_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next   = state_reg;
        wrap_next    = wrap_reg;
        err_next     = err_reg;
        cell_next    = cell_reg;
        cmd          = '0;
        cmd.cur_op   = tcw_pkg::CUR_HOLD;
        cmd.sweep_op = tcw_pkg::SWP_NONE;
        cmd.mem_op   = tcw_pkg::MEM_NONE;
        unique case (state_reg)
            ST_INIT: begin
                cmd.mem_op   = tcw_pkg::MEM_FILL_ZERO;
                cmd.sweep_op = tcw_pkg::SWP_STEP;
                if (sts.sweep_done) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                err_next  = 1'b0;
                cell_next = 1'b0;
                unique case (sts.action)
                    tcw_pkg::ACT_PRINT: begin
                        if (sts.col_at_end) begin
                            wrap_next  = 1'b1;
                            state_next = ST_NEXT_LINE;
                        end else if (sts.char_is_nl) begin
                            wrap_next  = 1'b0;
                            state_next = ST_NEXT_LINE;
                        end else begin
                            state_next = ST_WRITE_CHAR;
                        end
                    end
                    tcw_pkg::ACT_SET_CUR: begin
                        if (sts.set_ok) begin
                            cmd.cur_op = tcw_pkg::CUR_SET_ARG;
                        end else begin
                            err_next = 1'b1;
                        end
                        state_next = ST_FINISH;
                    end
                    tcw_pkg::ACT_CLEAR_ROW: begin
                        if (sts.row_ok) begin
                            cmd.sweep_op = tcw_pkg::SWP_ROW;
                            cmd.cur_op   = tcw_pkg::CUR_HOME_ROW;
                            state_next   = ST_BLANK_SWEEP;
                        end else begin
                            err_next   = 1'b1;
                            state_next = ST_FINISH;
                        end
                    end
                    tcw_pkg::ACT_CLEAR_ALL: begin
                        cmd.sweep_op = tcw_pkg::SWP_ALL;
                        cmd.cur_op   = tcw_pkg::CUR_HOME;
                        state_next   = ST_BLANK_SWEEP;
                    end
                    tcw_pkg::ACT_READ: begin
                        if (sts.read_ok) begin
                            cmd.mem_op = tcw_pkg::MEM_READ_ARG;
                            state_next = ST_READ_WAIT;
                        end else begin
                            err_next   = 1'b1;
                            state_next = ST_FINISH;
                        end
                    end
                    default: begin
                        err_next   = 1'b1;
                        state_next = ST_FINISH;
                    end
                endcase
            end
            ST_NEXT_LINE: begin
                if (sts.line_at_last) begin
                    cmd.sweep_op = tcw_pkg::SWP_COPY;
                    state_next   = ST_COPY;
                end else begin
                    cmd.cur_op = tcw_pkg::CUR_NEXT_LINE;
                    state_next = ST_AFTER_LINE;
                end
            end
            ST_COPY: begin
                cmd.mem_op   = tcw_pkg::MEM_COPY;
                cmd.sweep_op = tcw_pkg::SWP_STEP;
                if (sts.sweep_done) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                cmd.sweep_op = tcw_pkg::SWP_LAST;
                state_next   = ST_BLANK_LAST;
            end
            ST_BLANK_LAST: begin
                cmd.mem_op   = tcw_pkg::MEM_FILL_BLANK;
                cmd.sweep_op = tcw_pkg::SWP_STEP;
                if (sts.sweep_done) begin
                    cmd.cur_op = tcw_pkg::CUR_NEXT_LINE;
                    state_next = ST_AFTER_LINE;
                end
            end
            ST_AFTER_LINE: begin
                if (wrap_reg && sts.char_is_nl) begin
                    wrap_next  = 1'b0;
                    state_next = ST_NEXT_LINE;
                end else if (wrap_reg) begin
                    state_next = ST_WRITE_CHAR;
                end else begin
                    state_next = ST_FINISH;
                end
            end
            ST_WRITE_CHAR: begin
                cmd.mem_op = tcw_pkg::MEM_WRITE_CHAR;
                cmd.cur_op = tcw_pkg::CUR_ADVANCE;
                state_next = ST_FINISH;
            end
            ST_BLANK_SWEEP: begin
                cmd.mem_op   = tcw_pkg::MEM_FILL_BLANK;
                cmd.sweep_op = tcw_pkg::SWP_STEP;
                if (sts.sweep_done) begin
                    state_next = ST_FINISH;
                end
            end
            ST_READ_WAIT: begin
                cell_next  = 1'b1;
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (sts.out_free) begin
                    cmd.res_load = 1'b1;
                    cmd.res_err  = err_reg;
                    cmd.res_cell = cell_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/tcw_dp.sv -----
module tcw_dp #(
    parameter int ROWS = 25,
    parameter int COLS = 80
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  tcw_pkg::cmd_t                 cmd,
    output tcw_pkg::sts_t                 sts,
    input  logic [tcw_pkg::ACT_W-1:0]     in_action,
    input  logic [tcw_pkg::CHAR_W-1:0]    in_char_code,
    input  logic [tcw_pkg::COLA_W-1:0]    in_column_arg,
    input  logic [tcw_pkg::ROWA_W-1:0]    in_row_arg,
    input  logic                          cfg_valid,
    input  logic [tcw_pkg::COLOR_W-1:0]   cfg_data,
    input  logic                          m_tready,
    output logic                          m_tvalid,
    output logic [tcw_pkg::CELL_W-1:0]    out_cell_data,
    output logic [tcw_pkg::CCOL_W-1:0]    out_cursor_column,
    output logic [tcw_pkg::CROW_W-1:0]    out_cursor_row,
    output logic [tcw_pkg::POS_W-1:0]     out_cursor_position,
    output logic                          out_status
);

    localparam int unsigned N  = ROWS * COLS;
    localparam int unsigned AW = $clog2(N);
    localparam int unsigned CW = $clog2(COLS + 1);
    localparam int unsigned LW = $clog2(ROWS);
    localparam logic [AW-1:0] COLS_AW   = AW'(COLS);
    localparam logic [AW-1:0] LAST_ADDR = AW'(N - 1);
    localparam logic [AW-1:0] LAST_ROW  = AW'((ROWS - 1) * COLS);
    localparam logic [AW-1:0] COPY_END  = AW'((ROWS - 1) * COLS - 1);
    localparam logic [tcw_pkg::POS_W-1:0] COLS_POS = tcw_pkg::POS_W'(COLS);

    logic [tcw_pkg::ACT_W-1:0]   act_reg;
    logic [tcw_pkg::CHAR_W-1:0]  char_reg;
    logic [tcw_pkg::COLA_W-1:0]  col_arg_reg;
    logic [tcw_pkg::ROWA_W-1:0]  row_arg_reg;
    logic [tcw_pkg::COLOR_W-1:0] color_reg;
    logic [CW-1:0]               cur_col_reg, cur_col_next;
    logic [LW-1:0]               cur_line_reg, cur_line_next;
    logic [AW-1:0]               sweep_addr_reg, sweep_addr_next;
    logic [AW-1:0]               sweep_end_reg, sweep_end_next;
    logic                        copy_wr_reg;
    logic [AW-1:0]               copy_addr_reg;
    logic [tcw_pkg::CELL_W-1:0]  rd_data_reg;
    logic                        m_tvalid_reg;

    logic [tcw_pkg::CELL_W-1:0]  mem [N];
    logic                        mem_we;
    logic [AW-1:0]               mem_wa;
    logic [tcw_pkg::CELL_W-1:0]  mem_wd;
    logic                        mem_re;
    logic [AW-1:0]               mem_ra;

    logic [AW-1:0] row_base;
    logic [AW-1:0] arg_addr;
    logic [AW-1:0] cur_addr;
    logic          line_last;

    assign row_base  = AW'(AW'(row_arg_reg) * COLS_AW);
    assign arg_addr  = AW'(row_base + AW'(col_arg_reg));
    assign cur_addr  = AW'(AW'(AW'(cur_line_reg) * COLS_AW) + AW'(cur_col_reg));
    assign line_last = (int'(cur_line_reg) == ROWS - 1);

    assign sts.action       = act_reg;
    assign sts.char_is_nl   = (char_reg == tcw_pkg::NEWLINE_CODE);
    assign sts.col_at_end   = (int'(cur_col_reg) >= COLS);
    assign sts.line_at_last = line_last;
    assign sts.set_ok       = (int'(col_arg_reg) <= COLS) && (int'(row_arg_reg) < ROWS);
    assign sts.row_ok       = (int'(row_arg_reg) < ROWS);
    assign sts.read_ok      = (int'(col_arg_reg) < COLS) && (int'(row_arg_reg) < ROWS);
    assign sts.sweep_done   = (sweep_addr_reg == sweep_end_reg);
    assign sts.out_free     = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            act_reg     <= in_action;
            char_reg    <= in_char_code;
            col_arg_reg <= in_column_arg;
            row_arg_reg <= in_row_arg;
        end
    end

    always_comb begin
        cur_col_next  = cur_col_reg;
        cur_line_next = cur_line_reg;
        unique case (cmd.cur_op)
            tcw_pkg::CUR_HOLD: begin
            end
            tcw_pkg::CUR_SET_ARG: begin
                cur_col_next  = CW'(col_arg_reg);
                cur_line_next = LW'(row_arg_reg);
            end
            tcw_pkg::CUR_NEXT_LINE: begin
                cur_col_next = '0;
                if (!line_last) begin
                    cur_line_next = LW'(cur_line_reg + 1'b1);
                end
            end
            tcw_pkg::CUR_HOME_ROW: begin
                cur_col_next  = '0;
                cur_line_next = LW'(row_arg_reg);
            end
            tcw_pkg::CUR_HOME: begin
                cur_col_next  = '0;
                cur_line_next = '0;
            end
            tcw_pkg::CUR_ADVANCE: begin
                cur_col_next = CW'(cur_col_reg + 1'b1);
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        sweep_addr_next = sweep_addr_reg;
        sweep_end_next  = sweep_end_reg;
        unique case (cmd.sweep_op)
            tcw_pkg::SWP_NONE: begin
            end
            tcw_pkg::SWP_ALL: begin
                sweep_addr_next = '0;
                sweep_end_next  = LAST_ADDR;
            end
            tcw_pkg::SWP_ROW: begin
                sweep_addr_next = row_base;
                sweep_end_next  = AW'(row_base + COLS_AW - 1'b1);
            end
            tcw_pkg::SWP_LAST: begin
                sweep_addr_next = LAST_ROW;
                sweep_end_next  = LAST_ADDR;
            end
            tcw_pkg::SWP_COPY: begin
                sweep_addr_next = '0;
                sweep_end_next  = COPY_END;
            end
            tcw_pkg::SWP_STEP: begin
                sweep_addr_next = AW'(sweep_addr_reg + 1'b1);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            color_reg      <= tcw_pkg::COLOR_RESET;
            cur_col_reg    <= '0;
            cur_line_reg   <= '0;
            sweep_addr_reg <= '0;
            sweep_end_reg  <= LAST_ADDR;
            copy_wr_reg    <= 1'b0;
        end else begin
            if (cfg_valid) begin
                color_reg <= cfg_data;
            end
            cur_col_reg    <= cur_col_next;
            cur_line_reg   <= cur_line_next;
            sweep_addr_reg <= sweep_addr_next;
            sweep_end_reg  <= sweep_end_next;
            copy_wr_reg    <= (cmd.mem_op == tcw_pkg::MEM_COPY);
        end
    end

    always_ff @(posedge aclk) begin
        copy_addr_reg <= sweep_addr_reg;
    end

    always_comb begin
        mem_we = 1'b0;
        mem_wa = sweep_addr_reg;
        mem_wd = '0;
        mem_re = 1'b0;
        mem_ra = arg_addr;
        if (copy_wr_reg) begin
            mem_we = 1'b1;
            mem_wa = copy_addr_reg;
            mem_wd = rd_data_reg;
        end
        unique case (cmd.mem_op)
            tcw_pkg::MEM_NONE: begin
            end
            tcw_pkg::MEM_FILL_ZERO: begin
                mem_we = 1'b1;
            end
            tcw_pkg::MEM_FILL_BLANK: begin
                mem_we = 1'b1;
                mem_wd = {color_reg, tcw_pkg::BLANK_CODE};
            end
            tcw_pkg::MEM_WRITE_CHAR: begin
                mem_we = 1'b1;
                mem_wa = cur_addr;
                mem_wd = {color_reg, char_reg};
            end
            tcw_pkg::MEM_READ_ARG: begin
                mem_re = 1'b1;
            end
            tcw_pkg::MEM_COPY: begin
                mem_re = 1'b1;
                mem_ra = AW'(sweep_addr_reg + COLS_AW);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_re) begin
            rd_data_reg <= mem[mem_ra];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.res_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.res_load) begin
            out_cell_data       <= cmd.res_cell ? rd_data_reg : '0;
            out_cursor_column   <= tcw_pkg::CCOL_W'(cur_col_reg);
            out_cursor_row      <= tcw_pkg::CROW_W'(cur_line_reg);
            out_cursor_position <= tcw_pkg::POS_W'(tcw_pkg::POS_W'(cur_col_reg)
                                 + tcw_pkg::POS_W'(tcw_pkg::POS_W'(cur_line_reg) * COLS_POS));
            out_status          <= cmd.res_err;
        end
    end

    assign m_tvalid = m_tvalid_reg;

endmodule

// ----- rtl/text_console_writer.sv -----
// Text console writer: a ROWS x COLS screen store of 16-bit cells with a cursor.
// Input beats on s_*: s_tuser carries the action (print, set cursor, clear row,
// clear screen, read cell); s_tdata carries the character and the cursor/row
// arguments. Each input beat yields exactly one result beat on m_*: the cell
// read (zero for other actions), the cursor after the action, its linear
// position and an error flag.
// cfg_* writes the attribute byte used for printed and blanked cells; write it
// only while no action is in flight.
// Clear row and clear screen blank their cells one per cycle before the result is
// loaded. s_tready returns at the same edge that loads the result, so a new beat
// is accepted only after the previous result has been loaded.
// A newline or wrap on the last row scrolls: the store copies each cell up one row,
// one cell per cycle, and then blanks the last row.
// After reset the block sweeps zeros through all ROWS*COLS cells, one per cycle,
// with s_tready low; cfg writes are taken during that sweep.
// The result register frees the engine only when taken: a stalled m_tready holds
// the finished beat and the next action waits in its final step; s_tready stays
// high only while the engine is idle.
module text_console_writer #(
    parameter int ROWS = 25,
    parameter int COLS = 80
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // char_code[7:0], column_arg[14:8], row_arg[19:15], zero pad
    input  logic [2:0]  s_tuser,   // action[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // cell_data[15:0], cursor_column[22:16], cursor_row[27:23],
                                   // cursor_position[38:28], status[39]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data
);

    tcw_pkg::cmd_t cmd;
    tcw_pkg::sts_t sts;

    logic [tcw_pkg::CELL_W-1:0] cell_data;
    logic [tcw_pkg::CCOL_W-1:0] cursor_column;
    logic [tcw_pkg::CROW_W-1:0] cursor_row;
    logic [tcw_pkg::POS_W-1:0]  cursor_position;
    logic                       status;

    assign cfg_ready = 1'b1;

    tcw_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    tcw_dp #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_dp (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cmd                 (cmd),
        .sts                 (sts),
        .in_action           (s_tuser),
        .in_char_code        (s_tdata[7:0]),
        .in_column_arg       (s_tdata[14:8]),
        .in_row_arg          (s_tdata[19:15]),
        .cfg_valid           (cfg_valid),
        .cfg_data            (cfg_data),
        .m_tready            (m_tready),
        .m_tvalid            (m_tvalid),
        .out_cell_data       (cell_data),
        .out_cursor_column   (cursor_column),
        .out_cursor_row      (cursor_row),
        .out_cursor_position (cursor_position),
        .out_status          (status)
    );

    assign m_tdata = {status, cursor_position, cursor_row, cursor_column, cell_data};

endmodule

// ----- verif/tcw_checker.sv -----
module tcw_checker
    import tcw_pkg::*;
#(
    parameter int ROWS = 25,
    parameter int COLS = 80
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,   // char_code, column_arg, row_arg, zero pad
    input  logic [2:0]  s_tuser,   // action
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,   // cell_data, cursor_column, cursor_row, cursor_position,
                                   // status
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [7:0]  cfg_data,
    output int          mismatches,
    output int          owed_count
);

    typedef struct packed {
        logic              err;
        logic [POS_W-1:0]  pos;
        logic [CROW_W-1:0] row;
        logic [CCOL_W-1:0] col;
        logic [CELL_W-1:0] cell_val;
    } console_beat_t;

    logic [CELL_W-1:0]  cells [ROWS*COLS];
    int unsigned        cur_col;
    int unsigned        cur_line;
    logic [COLOR_W-1:0] color;
    console_beat_t      owed_results [$];

    task automatic report_mismatch(string what, int unsigned got_v, int unsigned want_v);
        $display("%0t: %s mismatch: got 0x%0h, want 0x%0h", $time, what, got_v, want_v);
        mismatches++;
    endtask

    function automatic void blank_row(int unsigned r);
        int unsigned c;
        for (c = 0; c < COLS; c++) begin
            cells[r*COLS + c] = {color, BLANK_CODE};
        end
    endfunction

    function automatic void line_feed();
        int unsigned i;
        cur_col = 0;
        if (cur_line < ROWS - 1) begin
            cur_line++;
        end else begin
            for (i = 0; i < (ROWS - 1) * COLS; i++) begin
                cells[i] = cells[i + COLS];
            end
            blank_row(ROWS - 1);
        end
    endfunction

    function automatic console_beat_t advance_console(logic [ACT_W-1:0] act,
                                                      logic [CHAR_W-1:0] ch,
                                                      logic [COLA_W-1:0] col,
                                                      logic [ROWA_W-1:0] row);
        console_beat_t beat;
        int unsigned   r;
        beat = '0;
        case (act)
            ACT_PRINT: begin
                if (cur_col >= COLS) line_feed();
                if (ch == NEWLINE_CODE) begin
                    line_feed();
                end else if (cur_col < COLS && cur_line < ROWS) begin
                    cells[cur_line*COLS + cur_col] = {color, ch};
                    cur_col++;
                end
            end
            ACT_SET_CUR: begin
                if (32'(col) > COLS || 32'(row) >= ROWS) begin
                    beat.err = 1'b1;
                end else begin
                    cur_col  = 32'(col);
                    cur_line = 32'(row);
                end
            end
            ACT_CLEAR_ROW: begin
                if (32'(row) >= ROWS) begin
                    beat.err = 1'b1;
                end else begin
                    blank_row(32'(row));
                    cur_col  = 0;
                    cur_line = 32'(row);
                end
            end
            ACT_CLEAR_ALL: begin
                for (r = 0; r < ROWS; r++) blank_row(r);
                cur_col  = 0;
                cur_line = 0;
            end
            ACT_READ: begin
                if (32'(col) >= COLS || 32'(row) >= ROWS) begin
                    beat.err = 1'b1;
                end else begin
                    beat.cell_val = cells[32'(row)*COLS + 32'(col)];
                end
            end
            default: begin
                beat.err = 1'b1;
            end
        endcase
        beat.col = CCOL_W'(cur_col);
        beat.row = CROW_W'(cur_line);
        beat.pos = POS_W'(cur_col + COLS * cur_line);
        return beat;
    endfunction

    always @(posedge aclk) begin
        console_beat_t got;
        console_beat_t want;
        int unsigned   i;
        if (!aresetn) begin
            for (i = 0; i < ROWS * COLS; i++) cells[i] = '0;
            cur_col  = 0;
            cur_line = 0;
            color    = COLOR_RESET;
            owed_results.delete();
            owed_count <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = console_beat_t'(m_tdata);
                if (owed_results.size() == 0) begin
                    report_mismatch("unexpected result beat", m_tdata[31:0], 0);
                end else begin
                    want = owed_results.pop_front();
                    if (got.cell_val != want.cell_val) begin
                        report_mismatch("cell_data", got.cell_val, want.cell_val);
                    end
                    if (got.col != want.col) report_mismatch("cursor_column", got.col, want.col);
                    if (got.row != want.row) report_mismatch("cursor_row", got.row, want.row);
                    if (got.pos != want.pos) report_mismatch("cursor_position", got.pos, want.pos);
                    if (got.err != want.err) report_mismatch("status", got.err, want.err);
                end
            end
            if (cfg_valid && cfg_ready) color = cfg_data;
            if (s_tvalid && s_tready) begin
                owed_results.push_back(advance_console(s_tuser, s_tdata[7:0], s_tdata[14:8],
                                                       s_tdata[19:15]));
            end
            owed_count <= owed_results.size();
        end
    end

endmodule

// ----- verif/testbench.sv -----
module testbench;
    import tcw_pkg::*;

    localparam int ROWS        = 25;
    localparam int COLS        = 80;
    localparam int ITEMS       = 1300;
    localparam int PHASES      = 6;
    localparam int CALM_ITEMS  = 150;
    localparam int HOLD_CYCLES = 400;
    localparam int SETTLE      = 200;
    localparam longint LIMIT   = 3_000_000;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic [23:0] s_tdata   = '0;
    logic [2:0]  s_tuser   = '0;
    logic        m_tready  = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [7:0]  cfg_data  = '0;
    logic        s_tready;
    logic        m_tvalid;
    logic [39:0] m_tdata;
    logic        cfg_ready;
    int          mismatches;
    int          owed_count;

    int     sent        = 0;
    int     calm_from   = ITEMS;
    bit     calm        = 1'b0;
    bit     squeeze     = 1'b0;
    bit     holding     = 1'b0;
    longint cycle_count = 0;

    always #5 aclk = ~aclk;

    text_console_writer #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    tcw_checker #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .mismatches (mismatches),
        .owed_count (owed_count)
    );

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic send_item(logic [ACT_W-1:0] act, logic [CHAR_W-1:0] ch,
                             logic [COLA_W-1:0] col, logic [ROWA_W-1:0] row);
        s_tuser  <= act;
        s_tdata  <= {4'b0, row, col, ch};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        sent++;
        calm = (sent >= calm_from);
        if (!calm && !holding && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge aclk);
        end
    endtask

    task automatic drain_and_paint(logic [COLOR_W-1:0] attr);
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (owed_count != 0);
        cfg_data  <= attr;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic play_sequence();
        int               pick;
        int               k;
        logic [ROWA_W-1:0] line;
        logic [CHAR_W-1:0] ch;
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
            line = ROWA_W'($urandom_range(0, ROWS - 3));
            if ($urandom_range(0, 9) != 0) begin
                send_item(ACT_SET_CUR, 8'($urandom), 7'($urandom_range(0, COLS)), line);
            end
            repeat ($urandom_range(1, 12)) begin
                ch = ($urandom_range(0, 15) == 0) ? NEWLINE_CODE : 8'($urandom);
                send_item(ACT_PRINT, ch, 7'($urandom), 5'($urandom));
            end
            repeat ($urandom_range(1, 3)) begin
                send_item(ACT_READ, 8'($urandom), 7'($urandom_range(0, COLS - 1)),
                          line + 5'($urandom_range(0, 1)));
            end
        end else if (pick < 75) begin
            repeat ($urandom_range(1, 4)) begin
                send_item(ACT_READ, 8'($urandom), 7'($urandom_range(0, COLS - 1)),
                          5'($urandom_range(0, ROWS - 1)));
            end
        end else if (pick < 83) begin
            send_item(ACT_CLEAR_ROW, 8'($urandom), 7'($urandom),
                      5'($urandom_range(0, ROWS - 2)));
            k = $urandom_range(1, 4);
            repeat (k) send_item(ACT_PRINT, 8'($urandom), 7'($urandom), 5'($urandom));
        end else if (pick < 86) begin
            send_item(ACT_SET_CUR, 8'($urandom), 7'($urandom_range(0, COLS)), 5'(ROWS - 1));
            repeat ($urandom_range(1, 3)) begin
                ch = ($urandom_range(0, 1) == 0) ? NEWLINE_CODE : 8'($urandom);
                send_item(ACT_PRINT, ch, 7'($urandom), 5'($urandom));
            end
        end else if (pick < 87) begin
            send_item(ACT_CLEAR_ALL, 8'($urandom), 7'($urandom), 5'($urandom));
        end else begin
            send_item(3'($urandom), 8'($urandom), 7'($urandom), 5'($urandom));
        end
    endtask

    initial begin
        int n;
        @(posedge aclk);
        forever begin
            if (squeeze) begin
                squeeze = 1'b0;
                holding = 1'b1;
                m_tready <= 1'b0;
                for (n = 0; n < HOLD_CYCLES; n++) @(posedge aclk);
                holding = 1'b0;
            end else if (!calm && $urandom_range(0, 2) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge aclk);
            end
        end
    end

    initial begin
        int a;
        int p;
        int base;
        bit armed;
        armed = 1'b1;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        drain_and_paint(8'hFF);

        send_item(ACT_READ, 8'h00, 7'd0, 5'd0);
        send_item(ACT_READ, 8'h00, 7'(COLS - 1), 5'(ROWS - 1));
        send_item(ACT_READ, 8'h00, 7'(COLS), 5'd0);
        send_item(ACT_READ, 8'hFF, 7'h7F, 5'h1F);
        send_item(ACT_PRINT, 8'h00, 7'd0, 5'd0);
        send_item(ACT_SET_CUR, 8'h00, 7'(COLS + 1), 5'd0);
        send_item(ACT_SET_CUR, 8'h00, 7'd0, 5'(ROWS));
        send_item(ACT_SET_CUR, 8'h00, 7'(COLS), 5'(ROWS - 1));
        send_item(ACT_PRINT, 8'h41, 7'd0, 5'd0);
        send_item(ACT_SET_CUR, 8'h00, 7'(COLS), 5'd5);
        send_item(ACT_PRINT, NEWLINE_CODE, 7'd0, 5'd0);
        send_item(ACT_SET_CUR, 8'h00, 7'(COLS - 1), 5'd3);
        send_item(ACT_PRINT, 8'h78, 7'd0, 5'd0);
        send_item(ACT_PRINT, 8'h79, 7'd0, 5'd0);
        send_item(ACT_READ, 8'h00, 7'd0, 5'd4);
        send_item(ACT_SET_CUR, 8'h00, 7'd10, 5'(ROWS - 1));
        send_item(ACT_PRINT, NEWLINE_CODE, 7'd0, 5'd0);
        send_item(ACT_CLEAR_ROW, 8'h00, 7'd0, 5'(ROWS - 1));
        send_item(ACT_CLEAR_ROW, 8'h00, 7'd0, 5'(ROWS));
        send_item(ACT_CLEAR_ROW, 8'h00, 7'd0, 5'h1F);
        send_item(ACT_CLEAR_ROW, 8'h00, 7'd0, 5'd0);
        send_item(ACT_CLEAR_ALL, 8'h00, 7'd0, 5'd0);
        for (a = int'(ACT_READ) + 1; a < (1 << ACT_W); a++) begin
            send_item(ACT_W'(a), 8'($urandom), 7'($urandom), 5'($urandom));
        end
        send_item(ACT_READ, 8'h00, 7'd0, 5'(ROWS - 2));

        base = sent;
        calm_from = base + ITEMS - CALM_ITEMS;
        for (p = 0; p < PHASES; p++) begin
            case (p)
                0: drain_and_paint(8'h00);
                1: drain_and_paint(COLOR_RESET);
                default: drain_and_paint(8'($urandom));
            endcase
            while (sent < base + ITEMS * (p + 1) / PHASES) begin
                if (armed && sent >= base + ITEMS / 3) begin
                    armed = 1'b0;
                    squeeze = 1'b1;
                end
                play_sequence();
            end
        end

        s_tvalid <= 1'b0;
        do @(posedge aclk); while (owed_count != 0);
        repeat (SETTLE) @(posedge aclk);
        if (mismatches == 0 && owed_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/tcw_pkg.sv
rtl/tcw_ctrl.sv
rtl/tcw_dp.sv
rtl/text_console_writer.sv
verif/tcw_checker.sv
verif/testbench.sv
